@@ src/bha_pkg.sv @@
// Package for the bump heap allocator: field types, codes and the sequencer's control store.
`timescale 1ns / 1ps
package bha_pkg;

	// Fixed field widths
	localparam int OP_W   = 2;
	localparam int REQ_W  = 13;
	localparam int ADDR_W = 12;
	localparam int CNT_W  = 13;
	localparam int CAP_W  = 13;
	localparam int LS_W   = CNT_W + 1;   // live mark over payload size

	localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

	// Operation codes; any code other than alloc and free acts as a status query
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NOSPACE = 2'd1,
		STS_NOTLIVE = 2'd2
	} status_t;

	typedef logic [CAP_W-1:0] cap_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [REQ_W-1:0]  request_words;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] payload_address;
		logic [CNT_W-1:0]  used_words;
		logic [CNT_W-1:0]  live_blocks;
		logic              heap_full;
	} rsp_t;

	// Sequencer steps (microcode addresses)
	typedef enum logic [2:0] {
		UP_DISPATCH,
		UP_A_LINK,
		UP_A_COMMIT,
		UP_F_READ,
		UP_F_LINK,
		UP_F_REWIND,
		UP_FINISH,
		UP_CLEAR
	} step_t;

	// Datapath action of a step
	typedef enum logic [2:0] {
		ACT_IDLE,
		ACT_LINK_TAIL,
		ACT_PLACE,
		ACT_LOOKUP,
		ACT_UNLINK,
		ACT_REWIND,
		ACT_REPORT,
		ACT_SWEEP
	} act_t;

	// Jump condition of a step
	typedef enum logic [2:0] {
		JC_ACCEPT,   // wait for an item, branch on its operation
		JC_SEQ,      // go to nxt
		JC_FAIL,     // tgt on a failed check, else nxt
		JC_OUT,      // hold until the result register is free, then tgt
		JC_SWEEP     // hold until the clearing pass ends, then tgt
	} jc_t;

	typedef struct packed {
		act_t  act;
		jc_t   jc;
		step_t nxt;
		step_t tgt;
	} uword_t;

	// Control store
	function automatic uword_t ucode(step_t s);
		uword_t w;
		unique case (s)
			UP_DISPATCH: w = '{ACT_IDLE,      JC_ACCEPT, UP_A_LINK,   UP_F_READ};
			UP_A_LINK:   w = '{ACT_LINK_TAIL, JC_FAIL,   UP_A_COMMIT, UP_FINISH};
			UP_A_COMMIT: w = '{ACT_PLACE,     JC_SEQ,    UP_FINISH,   UP_FINISH};
			UP_F_READ:   w = '{ACT_LOOKUP,    JC_FAIL,   UP_F_LINK,   UP_FINISH};
			UP_F_LINK:   w = '{ACT_UNLINK,    JC_FAIL,   UP_F_REWIND, UP_FINISH};
			UP_F_REWIND: w = '{ACT_REWIND,    JC_SEQ,    UP_FINISH,   UP_FINISH};
			UP_FINISH:   w = '{ACT_REPORT,    JC_OUT,    UP_FINISH,   UP_DISPATCH};
			UP_CLEAR:    w = '{ACT_SWEEP,     JC_SWEEP,  UP_CLEAR,    UP_DISPATCH};
		endcase
		return w;
	endfunction

endpackage

@@ src/bha_chan_if.sv @@
// Valid/ready channel interface carrying one item of payload type T.
`timescale 1ns / 1ps
interface bha_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ src/bump_heap_allocator_core.sv @@
// Top level of the bump heap allocator: microcoded sequencer, state registers and header store.
`timescale 1ns / 1ps
// Word-addressed bump allocator with tail rewind. Each item on req (allocate, free or status
// query) gives one item on rsp with status, new payload address, live payload words, live
// block count and a full flag. Items are handled one at a time by a short microprogram over
// three header RAMs (live mark and size, backward link, forward link), each with one write
// and one read port. After the dispatch step a query goes straight to its report step, an
// allocation passes the link and commit steps first and a free the lookup, unlink and rewind
// steps. A refused allocation, or a free of an address below the header or past the heap,
// goes to the report step from its link or lookup step, and a free of a dead header from its
// unlink step. A stalled rsp holds its result; the next item is taken, runs up to its report
// step and waits there. After reset the block sweeps the live marks of all HEAP_WORDS headers,
// one a cycle, before it takes its first item; the capacity register on cfg may be written at
// any time the block is idle and is registered when its handshake completes.
module bump_heap_allocator_core #(
	parameter int HEAP_WORDS   = 4096,
	parameter int HEADER_WORDS = 1
) (
	input logic       clk,
	input logic       arst_n,
	bha_chan_if.sink   req,
	bha_chan_if.source rsp,
	bha_chan_if.sink   cfg
);

	localparam int AW = $clog2(HEAP_WORDS);
	localparam int OW = $clog2(HEAP_WORDS + 1);
	localparam int SW = ((OW > bha_pkg::REQ_W) ? OW : bha_pkg::REQ_W) + 2;
	localparam int CW = bha_pkg::CNT_W;

	// Sequencer state
	bha_pkg::step_t  upc_q, upc_d;
	bha_pkg::uword_t uc;

	// Allocator state
	logic [OW-1:0]               bump_q;
	logic [AW-1:0]               tail_q;
	logic [CW-1:0]               used_q;
	logic [CW-1:0]               blocks_q;
	logic                        empty_q;
	logic                        rewind_q;
	logic [AW-1:0]               clr_q;
	bha_pkg::cap_t               cap_q;
	bha_pkg::req_t               item_q;
	bha_pkg::status_t            status_q;
	logic [bha_pkg::ADDR_W-1:0]  addr_q;
	bha_pkg::rsp_t               out_q;
	logic                        out_valid_q;

	// Header RAM ports
	logic                    ls_we, prv_we, nxt_we;
	logic [AW-1:0]           ls_waddr, prv_waddr, nxt_waddr;
	logic [bha_pkg::LS_W-1:0] ls_wdata, ls_rd;
	logic [AW:0]             prv_wdata, nxt_wdata, prv_rd, nxt_rd;
	logic [AW-1:0]           ls_raddr, hdr_ix;

	// Datapath terms
	logic [SW-1:0] eff_cap, sum_used, sum_end, fa_ext, fa_hdr, pay_addr, rew_end;
	logic          alloc_fail, free_bad, fail, out_free, sweep_end, accept;
	logic          live_rd, has_prev, has_next;
	logic [CW-1:0] size_rd;
	logic [AW-1:0] prev_rd, next_rd;

	assign uc = bha_pkg::ucode(upc_q);

	// Capacity clipped to the heap, allocation checks
	assign eff_cap    = (SW'(cap_q) > SW'(HEAP_WORDS)) ? SW'(HEAP_WORDS) : SW'(cap_q);
	assign sum_used   = SW'(used_q) + SW'(item_q.request_words);
	assign sum_end    = SW'(bump_q) + SW'(HEADER_WORDS) + SW'(item_q.request_words);
	assign pay_addr   = SW'(bump_q) + SW'(HEADER_WORDS);
	assign alloc_fail = (item_q.request_words == '0) || (sum_used > eff_cap) ||
		(sum_end > eff_cap);

	// Free address checks
	assign fa_ext   = SW'(item_q.free_address);
	assign fa_hdr   = fa_ext - SW'(HEADER_WORDS);
	assign free_bad = (fa_ext < SW'(HEADER_WORDS)) || (fa_hdr >= SW'(HEAP_WORDS));
	assign hdr_ix   = fa_hdr[AW-1:0];

	// Header fields as read back
	assign live_rd  = ls_rd[CW];
	assign size_rd  = ls_rd[CW-1:0];
	assign has_prev = prv_rd[AW];
	assign prev_rd  = prv_rd[AW-1:0];
	assign has_next = nxt_rd[AW];
	assign next_rd  = nxt_rd[AW-1:0];
	assign rew_end  = SW'(tail_q) + SW'(HEADER_WORDS) + SW'(size_rd);

	assign out_free  = !out_valid_q || rsp.ready;
	assign sweep_end = (clr_q == AW'(HEAP_WORDS - 1));
	assign accept    = req.valid && req.ready;

	// Handshakes
	assign req.ready = (uc.jc == bha_pkg::JC_ACCEPT);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Next step
	always_comb begin
		upc_d = upc_q;
		unique case (uc.jc)
			bha_pkg::JC_ACCEPT: begin
				if (req.valid) begin
					if (req.data.operation == bha_pkg::OP_ALLOC) upc_d = uc.nxt;
					else if (req.data.operation == bha_pkg::OP_FREE) upc_d = uc.tgt;
					else upc_d = bha_pkg::UP_FINISH;
				end
			end
			bha_pkg::JC_SEQ:   upc_d = uc.nxt;
			bha_pkg::JC_FAIL:  upc_d = fail ? uc.tgt : uc.nxt;
			bha_pkg::JC_OUT:   if (out_free) upc_d = uc.tgt;
			bha_pkg::JC_SWEEP: if (sweep_end) upc_d = uc.tgt;
			default:           upc_d = upc_q;
		endcase
	end

	// Control word decode: check result and RAM port controls
	always_comb begin
		fail      = 1'b0;
		ls_we     = 1'b0;
		ls_waddr  = hdr_ix;
		ls_wdata  = '0;
		ls_raddr  = hdr_ix;
		prv_we    = 1'b0;
		prv_waddr = hdr_ix;
		prv_wdata = '0;
		nxt_we    = 1'b0;
		nxt_waddr = hdr_ix;
		nxt_wdata = '0;
		unique case (uc.act)
			bha_pkg::ACT_LINK_TAIL: begin
				fail      = alloc_fail;
				nxt_we    = !alloc_fail && !empty_q;
				nxt_waddr = tail_q;
				nxt_wdata = {1'b1, bump_q[AW-1:0]};
			end
			bha_pkg::ACT_PLACE: begin
				ls_we     = 1'b1;
				ls_waddr  = bump_q[AW-1:0];
				ls_wdata  = {1'b1, item_q.request_words};
				prv_we    = 1'b1;
				prv_waddr = bump_q[AW-1:0];
				prv_wdata = empty_q ? '0 : {1'b1, tail_q};
				nxt_we    = 1'b1;
				nxt_waddr = bump_q[AW-1:0];
				nxt_wdata = '0;
			end
			bha_pkg::ACT_LOOKUP: begin
				fail = free_bad;
			end
			bha_pkg::ACT_UNLINK: begin
				fail      = !live_rd;
				// forward link of the previous block skips this one
				nxt_we    = live_rd && has_prev;
				nxt_waddr = prev_rd;
				nxt_wdata = has_next ? {1'b1, next_rd} : '0;
				// backward link of the next block skips this one
				prv_we    = live_rd && has_next;
				prv_waddr = next_rd;
				prv_wdata = has_prev ? {1'b1, prev_rd} : '0;
				// drop the live mark, fetch the previous size for a rewind
				ls_we     = live_rd;
				ls_waddr  = hdr_ix;
				ls_wdata  = '0;
				ls_raddr  = prev_rd;
			end
			bha_pkg::ACT_SWEEP: begin
				ls_we    = 1'b1;
				ls_waddr = clr_q;
				ls_wdata = '0;
			end
			default: begin
				fail = 1'b0;
			end
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= bha_pkg::UP_CLEAR;
		end else begin
			upc_q <= upc_d;
		end
	end

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bha_pkg::CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			cap_q <= cfg.data;
		end
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (uc.act == bha_pkg::ACT_SWEEP && !sweep_end) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Allocator state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q   <= '0;
			tail_q   <= '0;
			used_q   <= '0;
			blocks_q <= '0;
			empty_q  <= 1'b1;
			rewind_q <= 1'b0;
			status_q <= bha_pkg::STS_OK;
			addr_q   <= '0;
		end else begin
			case (uc.act)
				bha_pkg::ACT_IDLE: begin
					if (accept) begin
						status_q <= bha_pkg::STS_OK;
						addr_q   <= '0;
						rewind_q <= 1'b0;
					end
				end
				bha_pkg::ACT_LINK_TAIL: begin
					if (alloc_fail) status_q <= bha_pkg::STS_NOSPACE;
				end
				bha_pkg::ACT_PLACE: begin
					tail_q   <= bump_q[AW-1:0];
					empty_q  <= 1'b0;
					used_q   <= sum_used[CW-1:0];
					blocks_q <= blocks_q + CW'(1);
					bump_q   <= sum_end[OW-1:0];
					addr_q   <= pay_addr[bha_pkg::ADDR_W-1:0];
				end
				bha_pkg::ACT_LOOKUP: begin
					if (free_bad) status_q <= bha_pkg::STS_NOTLIVE;
				end
				bha_pkg::ACT_UNLINK: begin
					if (!live_rd) begin
						status_q <= bha_pkg::STS_NOTLIVE;
					end else begin
						used_q <= (used_q >= size_rd) ? used_q - size_rd : '0;
						if (blocks_q != '0) blocks_q <= blocks_q - CW'(1);
						// freed tail: rewind to the previous block or to an empty heap
						if (!has_next && has_prev) begin
							tail_q   <= prev_rd;
							rewind_q <= 1'b1;
						end else if (!has_next) begin
							bump_q  <= '0;
							tail_q  <= '0;
							empty_q <= 1'b1;
						end
					end
				end
				bha_pkg::ACT_REWIND: begin
					if (rewind_q) bump_q <= rew_end[OW-1:0];
				end
				default: begin
					rewind_q <= rewind_q;
				end
			endcase
		end
	end

	// Latched item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req.data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uc.act == bha_pkg::ACT_REPORT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.act == bha_pkg::ACT_REPORT && out_free) begin
			out_q.status          <= status_q;
			out_q.payload_address <= addr_q;
			out_q.used_words      <= used_q;
			out_q.live_blocks     <= blocks_q;
			out_q.heap_full       <= (SW'(used_q) >= eff_cap);
		end
	end

	// Header store: live mark and size, backward link, forward link
	bha_ram #(.WIDTH(bha_pkg::LS_W), .DEPTH(HEAP_WORDS)) u_ls_ram (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_waddr),
		.wdata (ls_wdata),
		.raddr (ls_raddr),
		.rdata (ls_rd)
	);

	bha_ram #(.WIDTH(AW + 1), .DEPTH(HEAP_WORDS)) u_prv_ram (
		.clk   (clk),
		.we    (prv_we),
		.waddr (prv_waddr),
		.wdata (prv_wdata),
		.raddr (hdr_ix),
		.rdata (prv_rd)
	);

	bha_ram #(.WIDTH(AW + 1), .DEPTH(HEAP_WORDS)) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.raddr (hdr_ix),
		.rdata (nxt_rd)
	);

	// Block count and list state agree between items
	a_count_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == bha_pkg::UP_DISPATCH) |-> ((blocks_q == '0) == empty_q))
		else $error("block count disagrees with empty list");

	// An empty list leaves no offset and no used words
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == bha_pkg::UP_DISPATCH && empty_q) |-> (bump_q == '0 && used_q == '0))
		else $error("empty list with nonzero offset or used words");

	// A report lands in the result register with the current totals
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		(uc.act == bha_pkg::ACT_REPORT && out_free) |=>
		(rsp.valid && rsp.data.used_words == $past(used_q)))
		else $error("result not presented after report step");

endmodule

@@ src/bha_ram.sv @@
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module bha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
